[hw/rtl/slt_pkg.sv]
// Shared types, constants and the quarter-wave sine table for the tremolo block.
// No dependencies; imported by every module of the block.
package slt_pkg;

	localparam int SAMPLE_BITS      = 24;
	localparam int PHASE_BITS       = 24;
	localparam int SINE_TABLE_DEPTH = 256;    // power of two
	localparam int TAB_BITS         = $clog2(SINE_TABLE_DEPTH);

	localparam int STEP_W  = 24;
	localparam int DEPTH_W = 16;
	localparam int ADDR_W  = 3;
	localparam int DATA_W  = 32;
	localparam logic [DEPTH_W-1:0] DEPTH_FULL = 16'd32768;

	// register index, taken from paddr[2]
	localparam logic REG_PHASE_STEP = 1'b0;
	localparam logic REG_MOD_DEPTH  = 1'b1;

	// decoupling queue
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic signed [15:0]            sine;    // Q1.15
	} slt_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} slt_qstat_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_GAIN,
		B_PROD,
		B_WRITE
	} slt_bstate_t;

	// Quarter-wave table, Q1.15 magnitudes, built at elaboration with a
	// Q30 Taylor series (terms up to x^13/13!).
	typedef logic [14:0] sine_tab_t [SINE_TABLE_DEPTH];

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t   tab;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			x  = (64'(k) * Q30_HALF_PI) / SINE_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			t  = Q30_ONE;
			t  = Q30_ONE - (((x2 * t) >> 30) / 156);
			t  = Q30_ONE - (((x2 * t) >> 30) / 110);
			t  = Q30_ONE - (((x2 * t) >> 30) / 72);
			t  = Q30_ONE - (((x2 * t) >> 30) / 42);
			t  = Q30_ONE - (((x2 * t) >> 30) / 20);
			t  = Q30_ONE - (((x2 * t) >> 30) / 6);
			s  = (x * t) >> 30;
			s  = (s + 64'd16384) >> 15;
			if (s > 64'd32767) begin
				s = 64'd32767;
			end
			tab[k] = s[14:0];
		end
		return tab;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

[hw/rtl/slt_front.sv]
// Front end: takes sample requests, looks up the LFO sine for the current
// phase and advances the phase accumulator. Depends on slt_pkg.
module slt_front
	import slt_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [STEP_W-1:0]             phase_step,
	input  slt_qstat_t                    qstat,
	output logic                          q_wr,
	output slt_entry_t                    q_wr_data
);

	localparam int QB = PHASE_BITS - 2;

	logic [PHASE_BITS-1:0]        phase_q;
	logic [PHASE_BITS+STEP_W-1:0] step_wide;
	logic [PHASE_BITS-1:0]        step_al;
	logic [QB-1:0]                frac;
	logic [QB+TAB_BITS-1:0]       frac_wide;
	logic [TAB_BITS-1:0]          idx;
	logic signed [15:0]           mag;

	assign full = qstat.full;
	assign q_wr = push && !qstat.full;

	// step is a 24-bit fraction; rescale to the accumulator width
	assign step_wide = {phase_step, {PHASE_BITS{1'b0}}};
	assign step_al   = step_wide[PHASE_BITS+STEP_W-1:STEP_W];

	// mirror in odd quadrants, negate in the second half of the cycle
	assign frac      = phase_q[QB-1:0] ^ {QB{phase_q[QB]}};
	assign frac_wide = {frac, {TAB_BITS{1'b0}}};
	assign idx       = frac_wide[QB+TAB_BITS-1:QB];
	assign mag       = $signed({1'b0, SINE_TAB[idx]});

	assign q_wr_data.sample = sample_in;
	assign q_wr_data.sine   = phase_q[PHASE_BITS-1] ? -mag : mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (q_wr) begin
			phase_q <= phase_q + step_al;
		end
	end

endmodule

[hw/rtl/slt_fifo.sv]
// Short queue between front and back end, flop based.
// Depends on slt_pkg.
module slt_fifo
	import slt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  slt_entry_t wr_data,
	input  logic       rd_en,
	output slt_entry_t rd_data,
	output slt_qstat_t qstat
);

	slt_entry_t         mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign qstat.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign rd_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !qstat.full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !qstat.empty) else $error("queue read while empty");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow write");
`endif

endmodule

[hw/rtl/slt_back.sv]
// Back end: forms the LFO gain, multiplies, rounds and saturates, and holds
// the result for the output side. Depends on slt_pkg.
module slt_back
	import slt_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [DEPTH_W-1:0]            mod_depth,
	input  slt_qstat_t                    qstat,
	input  slt_entry_t                    q_rd_data,
	output logic                          q_rd,
	input  logic                          pop,
	output logic                          empty,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	localparam int GAIN_W = 33;
	localparam int PROD_W = SAMPLE_BITS + GAIN_W;
	localparam int Y_W    = PROD_W - 31;
	localparam logic signed [Y_W-1:0] Y_MAX = {3'b000, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [Y_W-1:0] Y_MIN = {3'b111, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [PROD_W-1:0] RND = {{(PROD_W-31){1'b0}}, 1'b1, 30'b0};

	slt_bstate_t state_q, state_d;
	logic ld_gain, ld_prod, ld_out;

	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic signed [15:0]            sine_s1;
	logic signed [GAIN_W-1:0]      gain_s2;
	logic signed [PROD_W-1:0]      prod_s3;
	logic signed [SAMPLE_BITS-1:0] result_q;
	logic                          out_valid_q;

	logic signed [16:0]       sine_off;
	logic signed [16:0]       depth_s;
	logic signed [33:0]       gmul;
	logic signed [34:0]       gsum;
	logic signed [PROD_W-1:0] prod_next;
	logic signed [PROD_W-1:0] rnd;
	logic signed [Y_W-1:0]    y;
	logic signed [Y_W-1:0]    y_sat;

	// gain = 2^31 + depth * (sine - 1.0), Q1.31
	assign sine_off  = 17'(sine_s1) - 17'sd32768;
	assign depth_s   = $signed({1'b0, mod_depth});
	assign gmul      = depth_s * sine_off;
	assign gsum      = 35'sd2147483648 + 35'(gmul);
	assign prod_next = PROD_W'(sample_s1) * PROD_W'(gain_s2);

	// round half up at bit 31, then clamp
	assign rnd = prod_s3 + RND;
	assign y   = $signed(rnd[PROD_W-1:31]);
	always_comb begin
		if (y > Y_MAX) begin
			y_sat = Y_MAX;
		end else if (y < Y_MIN) begin
			y_sat = Y_MIN;
		end else begin
			y_sat = y;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE:  if (!qstat.empty) state_d = B_GAIN;
			B_GAIN:  state_d = B_PROD;
			B_PROD:  state_d = B_WRITE;
			B_WRITE: if (!out_valid_q || pop) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		q_rd    = 1'b0;
		ld_gain = 1'b0;
		ld_prod = 1'b0;
		ld_out  = 1'b0;
		case (state_q)
			B_IDLE:  q_rd = !qstat.empty;
			B_GAIN:  ld_gain = 1'b1;
			B_PROD:  ld_prod = 1'b1;
			B_WRITE: ld_out = !out_valid_q || pop;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			sample_s1 <= q_rd_data.sample;
			sine_s1   <= q_rd_data.sine;
		end
		if (ld_gain) begin
			gain_s2 <= gsum[GAIN_W-1:0];
		end
		if (ld_prod) begin
			prod_s3 <= prod_next;
		end
		if (ld_out) begin
			result_q <= y_sat[SAMPLE_BITS-1:0];
		end
	end

	assign empty      = !out_valid_q;
	assign sample_out = result_q;

`ifndef SYNTHESIS
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WRITE && out_valid_q && !pop) |=> (out_valid_q && $stable(result_q)))
		else $error("waiting result overwritten");
`endif

endmodule

[hw/rtl/sine_lfo_tremolo.sv]
// Sine LFO tremolo, top level: register port and wiring of front, queue and back.
// Depends on slt_pkg, slt_front, slt_fifo, slt_back.
//
// Tremolo: every sample request pushed in comes back once, in order, scaled
// by gain = (1 - depth/2) + (depth/2)*sin(2*pi*phase), rounded half up and
// saturated to 24 bits. The phase used is the one held before the request;
// it then advances by phase_step (24-bit fraction of a cycle, wraps).
// Registers: phase_step at byte 0x0, mod_depth (Q1.15, written values above
// 0x8000 read back as 0x8000) at 0x4; write only while no request is in flight.
// Timing: the front end takes a request every cycle while its four-entry
// queue has room; the back end works through one request at a time (queue
// read, gain multiply, sample multiply, round/saturate) and takes the next
// from the queue only after writing the last; the write waits while the
// output register holds a result not yet popped. There is no clearing pass.
module sine_lfo_tremolo
	import slt_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	// sample request side
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	// result side
	output logic                          empty,
	input  logic                          pop,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	// register port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready
);

	logic [STEP_W-1:0]  phase_step_q;
	logic [DEPTH_W-1:0] mod_depth_q;
	logic               reg_wr;
	logic [DEPTH_W-1:0] depth_wr;

	slt_qstat_t qstat;
	slt_entry_t q_wr_data;
	slt_entry_t q_rd_data;
	logic       q_wr;
	logic       q_rd;

	// register access: pready tied high, index from paddr[2]
	assign pready   = 1'b1;
	assign reg_wr   = psel && penable && pwrite && pready;
	assign depth_wr = (pwdata[DEPTH_W-1:0] > DEPTH_FULL) ? DEPTH_FULL : pwdata[DEPTH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= '0;
			mod_depth_q  <= '0;
		end else if (reg_wr) begin
			case (paddr[2])
				REG_PHASE_STEP: phase_step_q <= pwdata[STEP_W-1:0];
				REG_MOD_DEPTH:  mod_depth_q  <= depth_wr;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_PHASE_STEP: prdata = {{(DATA_W-STEP_W){1'b0}}, phase_step_q};
			REG_MOD_DEPTH:  prdata = {{(DATA_W-DEPTH_W){1'b0}}, mod_depth_q};
			default:        prdata = '0;
		endcase
	end

	// front: accept, sine lookup, phase advance
	slt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample_in  (sample_in),
		.phase_step (phase_step_q),
		.qstat      (qstat),
		.q_wr       (q_wr),
		.q_wr_data  (q_wr_data)
	);

	// decoupling queue
	slt_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wr_data),
		.rd_en   (q_rd),
		.rd_data (q_rd_data),
		.qstat   (qstat)
	);

	// back: gain, multiply, round/saturate, output holding register
	slt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mod_depth  (mod_depth_q),
		.qstat      (qstat),
		.q_rd_data  (q_rd_data),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.sample_out (sample_out)
	);

endmodule

[tb/tb.sv]
// Self-checking bench for sine_lfo_tremolo: queue-style sample driver, result monitor,
// bit-exact tremolo predictor and register programming over the APB-style port.
// Depends on slt_pkg and the sine_lfo_tremolo RTL.
module tb
	import slt_pkg::*;
();

	typedef logic signed [SAMPLE_BITS-1:0] audio_t;

	localparam int DRAIN_CYCLES   = 20;     // well past the push-to-result latency
	localparam int WATCHDOG_LIMIT = 4000;   // cycles with no request moving on either side
	localparam int LONG_HOLD      = 150;    // receiver back-pressure stretch
	localparam int PHASE_ITEMS    = 250;
	localparam longint Q30_UNITY  = 64'd1073741824;
	localparam longint Q30_QPI    = 64'd1686629713;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	audio_t              sample_in;
	logic                empty;
	logic                pop;
	audio_t              sample_out;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// samples waiting to be offered, and the scaled samples still owed by the block
	audio_t              pending_samples[$];
	audio_t              expected_out[$];

	// predictor copy of the block's state and registers
	logic [14:0]             qsine [SINE_TABLE_DEPTH];
	logic [PHASE_BITS-1:0]   lfo_phase_acc;
	logic [STEP_W-1:0]       step_cfg;
	logic [DEPTH_W-1:0]      depth_cfg;

	bit  calm_phase;        // no random gaps on either side while set
	int  mismatches;
	int  results_seen;
	int  push_gap;
	int  pop_gap;
	int  hold_left;
	int  stall_cycles;

	sine_lfo_tremolo DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.sample_in  (sample_in),
		.empty      (empty),
		.pop        (pop),
		.sample_out (sample_out),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		// keep the log bounded on a badly broken build; every hit still counts
		if (mismatches < 40) begin
			$display("MISMATCH @%0t: %s", $time, msg);
		end
		mismatches++;
	endtask

	// Quarter-wave magnitudes, Q1.15, via integer Taylor series in Q30
	// (nested form, terms up to x^13/13!), rounded half up and clamped.
	function automatic void fill_quarter_sine();
		longint unsigned divs[6];
		longint unsigned x, x2, t, s;
		divs = '{156, 110, 72, 42, 20, 6};
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			x  = (longint'(k) * Q30_QPI) / SINE_TABLE_DEPTH;
			x2 = (x * x) >> 30;
			t  = Q30_UNITY;
			foreach (divs[i]) begin
				t = Q30_UNITY - (((x2 * t) >> 30) / divs[i]);
			end
			s = ((x * t) >> 30);
			s = (s + 64'd16384) >> 15;
			if (s > 64'd32767) begin
				s = 64'd32767;
			end
			qsine[k] = s[14:0];
		end
	endfunction

	// Scaled sample for the phase held before the request.
	function automatic audio_t tremolo_out(audio_t s, logic [PHASE_BITS-1:0] ph,
			logic [DEPTH_W-1:0] depth);
		logic [1:0]            quad;
		logic [PHASE_BITS-3:0] frac;
		longint                idx, sine, gain, y, smax;
		quad = ph[PHASE_BITS-1 -: 2];
		frac = ph[PHASE_BITS-3:0];
		// odd quadrants run the table backwards, upper half is negated
		if (quad[0]) begin
			frac = ~frac;
		end
		idx  = (longint'(frac) * SINE_TABLE_DEPTH) >>> (PHASE_BITS - 2);
		sine = longint'(qsine[idx]);
		if (quad[1]) begin
			sine = -sine;
		end
		// Q1.31 gain: 1 - depth/2 + depth/2 * sin
		gain = (longint'(1) <<< 31) - (longint'(depth) <<< 15) + longint'(depth) * sine;
		// round half up at bit 31; arithmetic shift floors
		y    = (longint'(s) * gain + (longint'(1) <<< 30)) >>> 31;
		smax = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
		if (y > smax) begin
			y = smax;
		end
		if (y < -smax - 1) begin
			y = -smax - 1;
		end
		return audio_t'(y);
	endfunction

	function automatic logic [PHASE_BITS-1:0] aligned_step();
		int sh;
		if (PHASE_BITS >= STEP_W) begin
			sh = PHASE_BITS - STEP_W;
			return PHASE_BITS'(longint'(step_cfg) << sh);
		end else begin
			sh = STEP_W - PHASE_BITS;
			return PHASE_BITS'(longint'(step_cfg) >> sh);
		end
	endfunction

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end else begin
			return $urandom_range(10, 40);
		end
	endfunction

	function automatic audio_t rand_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			2: return audio_t'($signed($urandom_range(0, 511)) - 256);
			default: return audio_t'($urandom);
		endcase
	endfunction

	// Sample driver: fed from pending_samples; predicts each accepted request
	// and steps the predictor's phase accumulator after it.
	always @(posedge clk) begin
		if (push && !full) begin
			expected_out.push_back(tremolo_out(sample_in, lfo_phase_acc, depth_cfg));
			lfo_phase_acc = lfo_phase_acc + aligned_step();
			void'(pending_samples.pop_front());
		end
		// a held request under full keeps push and data stable
		if (!push || !full) begin
			if (push_gap > 0) begin
				push_gap--;
				push <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				push      <= 1'b1;
				sample_in <= pending_samples[0];
				push_gap  = calm_phase ? 0 : draw_gap();
			end else begin
				push <= 1'b0;
			end
		end
	end

	// Result monitor: checks each popped sample against the oldest prediction,
	// stalls at random and now and then holds off long enough to fill the block.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_out.size() == 0) begin
				report_mismatch($sformatf("result %0d with no request outstanding",
					sample_out));
			end else if (sample_out !== expected_out[0]) begin
				report_mismatch($sformatf("sample_out got %0d want %0d",
					sample_out, expected_out[0]));
				void'(expected_out.pop_front());
			end else begin
				void'(expected_out.pop_front());
			end
			results_seen++;
			if (results_seen % 500 == 200) begin
				hold_left = LONG_HOLD;
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (pop_gap > 0) begin
			pop_gap--;
			pop <= 1'b0;
		end else begin
			pop     <= 1'b1;
			pop_gap = calm_phase ? 0 : draw_gap();
		end
	end

	// watchdog: too long with no request moving on either side
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles == WATCHDOG_LIMIT) begin
			$display("sine_lfo_tremolo test failed");
			$finish;
		end
	end

	// one APB transfer: setup then access, done at the edge with pready high
	task automatic apb_xfer(input logic wr, input logic idx, input logic [DATA_W-1:0] data,
			output logic [DATA_W-1:0] rd);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// write a register, mirror it in the predictor, read it back
	task automatic program_reg(input logic idx, input logic [DATA_W-1:0] value);
		logic [DATA_W-1:0] rd;
		logic [DATA_W-1:0] want;
		apb_xfer(1'b1, idx, value, rd);
		if (idx == REG_PHASE_STEP) begin
			step_cfg = value[STEP_W-1:0];
			want     = DATA_W'(step_cfg);
		end else begin
			// depth above full scale saturates
			depth_cfg = (value[DEPTH_W-1:0] > DEPTH_FULL) ? DEPTH_FULL : value[DEPTH_W-1:0];
			want      = DATA_W'(depth_cfg);
		end
		apb_xfer(1'b0, idx, '0, rd);
		if (rd !== want) begin
			report_mismatch($sformatf("readback of register %0d got %h want %h",
				idx, rd, want));
		end
	endtask

	// block idle: nothing queued, nothing offered, nothing owed, pipeline flushed
	task automatic wait_drained();
		while (pending_samples.size() > 0 || push || expected_out.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		audio_t pos_max;
		audio_t neg_max;
		logic [DATA_W-1:0] step_val;
		logic [DATA_W-1:0] depth_val;

		clk       = 1'b0;
		arst_n    = 1'b0;
		push      = 1'b0;
		pop       = 1'b0;
		sample_in = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		lfo_phase_acc = '0;
		step_cfg      = '0;
		depth_cfg     = '0;
		calm_phase    = 1'b0;
		mismatches    = 0;
		results_seen  = 0;
		push_gap      = 0;
		pop_gap       = 0;
		hold_left     = 0;
		stall_cycles  = 0;
		pos_max = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		neg_max = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		fill_quarter_sine();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers: zero depth is unity gain, zero step holds phase
		pending_samples.push_back(pos_max);
		pending_samples.push_back(neg_max);
		pending_samples.push_back(audio_t'(0));
		pending_samples.push_back(audio_t'(1));
		pending_samples.push_back(audio_t'(-1));
		pending_samples.push_back(audio_t'(24'h555555));
		wait_drained();

		// full depth, quarter-cycle step: walks all four quadrants twice,
		// the sample using the phase from before its own step
		program_reg(REG_PHASE_STEP, 32'h0040_0000);
		program_reg(REG_MOD_DEPTH, DATA_W'(DEPTH_FULL));
		repeat (4) begin
			pending_samples.push_back(pos_max);
			pending_samples.push_back(neg_max);
		end
		wait_drained();

		// depth written beyond full scale, largest step (nearly a full cycle per sample)
		program_reg(REG_PHASE_STEP, 32'h00FF_FFFF);
		program_reg(REG_MOD_DEPTH, 32'h0000_FFFF);
		pending_samples.push_back(pos_max);
		pending_samples.push_back(neg_max);
		pending_samples.push_back(audio_t'(24'hAAAAAA));
		pending_samples.push_back(audio_t'(-2));
		wait_drained();

		// step just over half a cycle, half depth
		program_reg(REG_PHASE_STEP, 32'h0080_0001);
		program_reg(REG_MOD_DEPTH, 32'h0000_4000);
		pending_samples.push_back(pos_max);
		pending_samples.push_back(neg_max);
		pending_samples.push_back(audio_t'(12345));
		pending_samples.push_back(audio_t'(-12345));
		wait_drained();

		// six phases of random samples, one register setting each; phase 2 runs without idling
		// so the receiver's long hold-off backs the block up to a full input
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: begin
					step_val  = $urandom_range(1, 4095);
					depth_val = $urandom_range(0, 32768);
				end
				1: begin
					step_val  = 32'h00FF_FFFF;
					depth_val = DATA_W'(DEPTH_FULL);
				end
				2: begin
					step_val  = $urandom_range(0, 32'h00FF_FFFF);
					depth_val = 32'h0000_FFFF;
				end
				3: begin
					step_val  = 32'h0000_0000;
					depth_val = $urandom_range(0, 65535);
				end
				4: begin
					step_val  = 32'h0080_0000;
					depth_val = 32'h0000_0000;
				end
				default: begin
					step_val  = $urandom_range(0, 32'h00FF_FFFF);
					depth_val = $urandom_range(0, 65535);
				end
			endcase
			program_reg(REG_PHASE_STEP, step_val);
			program_reg(REG_MOD_DEPTH, depth_val);
			calm_phase = (p == 2);
			repeat (PHASE_ITEMS) pending_samples.push_back(rand_sample());
			wait_drained();
		end

		if (mismatches == 0) begin
			$display("sine_lfo_tremolo test passed");
		end else begin
			$display("sine_lfo_tremolo test failed");
		end
		$finish;
	end

endmodule

[sine_lfo_tremolo.f]
hw/rtl/slt_pkg.sv
hw/rtl/slt_front.sv
hw/rtl/slt_fifo.sv
hw/rtl/slt_back.sv
hw/rtl/sine_lfo_tremolo.sv
tb/tb.sv
